@@ rtl/core/lswps_pkg.sv @@
package lswps_pkg;

   // Request operations
   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_DATA    = 2'd1,
      OP_NIBBLE  = 2'd2,
      OP_CURSOR  = 2'd3
   } op_type;

   // Descriptor kinds
   typedef enum logic [1:0] {
      KIND_ZERO  = 2'd0,
      KIND_ONE   = 2'd1,
      KIND_LATCH = 2'd2,
      KIND_PAUSE = 2'd3
   } kind_type;

   // CSR indexes
   localparam logic [2:0] CSR_ZERO_LOW   = 3'd0;
   localparam logic [2:0] CSR_ZERO_HIGH  = 3'd1;
   localparam logic [2:0] CSR_ONE_LOW    = 3'd2;
   localparam logic [2:0] CSR_ONE_HIGH   = 3'd3;
   localparam logic [2:0] CSR_LATCH_LOW  = 3'd4;
   localparam logic [2:0] CSR_LATCH_HIGH = 3'd5;
   localparam logic [2:0] CSR_NIB_GAP    = 3'd6;
   localparam logic [2:0] CSR_CMD_GAP    = 3'd7;

   // CSR reset values
   localparam logic [15:0] RST_ZERO_LOW   = 16'd15;
   localparam logic [15:0] RST_ZERO_HIGH  = 16'd30;
   localparam logic [15:0] RST_ONE_LOW    = 16'd1;
   localparam logic [15:0] RST_ONE_HIGH   = 16'd15;
   localparam logic [15:0] RST_LATCH_LOW  = 16'd200;
   localparam logic [15:0] RST_LATCH_HIGH = 16'd300;
   localparam logic [15:0] RST_NIB_GAP    = 16'd100;
   localparam logic [15:0] RST_CMD_GAP    = 16'd5000;

   // Cursor row base addresses
   localparam logic [7:0] ROW1_BASE = 8'd127;
   localparam logic [7:0] ROW2_BASE = 8'd191;
   localparam logic [7:0] ROW3_BASE = 8'd147;
   localparam logic [7:0] ROW4_BASE = 8'd211;

   localparam logic [2:0] LEAD_US = 3'd5;

   // Positions within one nibble transfer
   localparam logic [3:0] POS_PASS1 = 4'd7;   // first bit of second pass
   localparam logic [2:0] Q_LATCH   = 3'd6;   // latch slot within a pass
   localparam logic [3:0] POS_GAP   = 4'd14;  // nibble gap

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] value;
      logic [2:0] row;
      logic [6:0] col;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  lead_high_us;
      logic [15:0] low_us;
      logic [15:0] high_us;
      logic        last;
   } rsp_type;

   // Classified job handed from front to back
   typedef struct packed {
      logic [7:0] byte_val;  // two nibbles, or low nibble only when !two_nib
      logic       rs;
      logic       two_nib;
      logic       cmd_gap;
   } job_type;

   typedef struct packed {
      logic [15:0] zero_low;
      logic [15:0] zero_high;
      logic [15:0] one_low;
      logic [15:0] one_high;
      logic [15:0] latch_low;
      logic [15:0] latch_high;
      logic [15:0] nib_gap;
      logic [15:0] cmd_gap;
   } cfg_type;

   // Queue status between the queue and its users
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ rtl/core/lcd_single_wire_pulse_serializer_core.sv @@
// A taken request is queued, then loaded into the sequencer, which registers its
// first descriptor. Throughput: one descriptor per cycle while rsp_stall is low;
//   descriptors per request: 15 (nibble), 30 (data), 31 (command/cursor), plus a load.
// The request queue takes up to QUEUE_DEPTH requests ahead of the sequencer.
// Reset: timing CSRs return to their defaults, queue empties, sequencer idles.
module lcd_single_wire_pulse_serializer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  lswps_pkg::req_type req,
   // descriptor channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lswps_pkg::rsp_type rsp,
   // CSR write port
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import lswps_pkg::*;

   // Timing CSRs, all in microseconds
   cfg_type   cfg_ff, cfg_in;

   qstat_type qstat;
   logic      q_push, q_pop;
   job_type   push_job, pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ZERO_LOW:   cfg_in.zero_low   = csr_wdata;
            CSR_ZERO_HIGH:  cfg_in.zero_high  = csr_wdata;
            CSR_ONE_LOW:    cfg_in.one_low    = csr_wdata;
            CSR_ONE_HIGH:   cfg_in.one_high   = csr_wdata;
            CSR_LATCH_LOW:  cfg_in.latch_low  = csr_wdata;
            CSR_LATCH_HIGH: cfg_in.latch_high = csr_wdata;
            CSR_NIB_GAP:    cfg_in.nib_gap    = csr_wdata;
            CSR_CMD_GAP:    cfg_in.cmd_gap    = csr_wdata;
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_low   <= RST_ZERO_LOW;
         cfg_ff.zero_high  <= RST_ZERO_HIGH;
         cfg_ff.one_low    <= RST_ONE_LOW;
         cfg_ff.one_high   <= RST_ONE_HIGH;
         cfg_ff.latch_low  <= RST_LATCH_LOW;
         cfg_ff.latch_high <= RST_LATCH_HIGH;
         cfg_ff.nib_gap    <= RST_NIB_GAP;
         cfg_ff.cmd_gap    <= RST_CMD_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify the request (byte, RS, nibble count, command gap)
   lswps_front u_front (
      .req_valid (req_valid),
      .req       (req),
      .qstat     (qstat),
      .req_stall (req_stall),
      .push      (q_push),
      .job       (push_job)
   );

   // Short queue decouples request acceptance from descriptor output
   lswps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .qstat     (qstat)
   );

   // Back: walks two passes, latch and gap per nibble, then the command gap if the job has one
   lswps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .job       (pop_job),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // A request is never pushed into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && qstat.full))
      else $error("push into full request queue");

   // The sequencer only loads when a request is waiting
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && qstat.empty))
      else $error("pop from empty request queue");

   // Pauses carry no pulse
   a_pause_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.kind == KIND_PAUSE) |->
         (rsp.lead_high_us == '0 && rsp.low_us == '0))
      else $error("pause descriptor with pulse timing");

   // A load cycle comes only with an empty output slot or a taken descriptor
   a_pop_after_out: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid || !rsp_stall))
      else $error("request loaded while descriptor stalled");

endmodule

@@ rtl/core/lswps_front.sv @@
module lswps_front (
   input  logic              req_valid,
   input  lswps_pkg::req_type req,
   input  lswps_pkg::qstat_type qstat,
   output logic              req_stall,
   output logic              push,
   output lswps_pkg::job_type job
);
   import lswps_pkg::*;

   logic [7:0] base;

   always_comb begin
      case (req.row)
         3'd2:    base = ROW2_BASE;
         3'd3:    base = ROW3_BASE;
         3'd4:    base = ROW4_BASE;
         default: base = ROW1_BASE;
      endcase
   end

   always_comb begin
      job = '0;
      case (op_type'(req.op))
         OP_COMMAND: begin
            job.byte_val = req.value;
            job.two_nib  = 1'b1;
            job.cmd_gap  = 1'b1;
         end
         OP_DATA: begin
            job.byte_val = req.value;
            job.rs       = 1'b1;
            job.two_nib  = 1'b1;
         end
         OP_NIBBLE: begin
            job.byte_val = {4'd0, req.value[3:0]};
         end
         default: begin
            // cursor move, sum wraps at 8 bits
            job.byte_val = base + {1'b0, req.col};
            job.two_nib  = 1'b1;
            job.cmd_gap  = 1'b1;
         end
      endcase
   end

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

endmodule

@@ rtl/core/lswps_queue.sv @@
module lswps_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lswps_pkg::job_type push_data,
   input  logic               pop,
   output lswps_pkg::job_type pop_data,
   output lswps_pkg::qstat_type qstat
);
   import lswps_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_data    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/lswps_back.sv @@
module lswps_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lswps_pkg::cfg_type   cfg,
   input  lswps_pkg::qstat_type qstat,
   input  lswps_pkg::job_type   job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lswps_pkg::rsp_type   rsp
);
   import lswps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NIB,
      ST_CMDGAP
   } state_type;

   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   logic       nib_sel_ff, nib_sel_in;   // 0 first nibble, 1 second
   logic [3:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       adv;
   logic       pass1;
   logic [2:0] q;
   logic [3:0] nib;
   logic       bit_val;
   logic       last_nib;
   rsp_type    desc;

   assign adv      = !rsp_valid_ff || !rsp_stall;
   assign pass1    = (pos_ff >= POS_PASS1);
   assign q        = pass1 ? 3'(pos_ff - POS_PASS1) : pos_ff[2:0];
   assign nib      = (!nib_sel_ff && job_ff.two_nib) ? job_ff.byte_val[7:4]
                                                     : job_ff.byte_val[3:0];
   assign last_nib = nib_sel_ff || !job_ff.two_nib;

   always_comb begin
      case (q)
         3'd0:    bit_val = !pass1;   // enable
         3'd1:    bit_val = job_ff.rs;
         3'd2:    bit_val = nib[3];
         3'd3:    bit_val = nib[2];
         3'd4:    bit_val = nib[1];
         default: bit_val = nib[0];
      endcase
   end

   // Descriptor for the current slot of a nibble transfer
   always_comb begin
      desc = '0;
      if (pos_ff == POS_GAP) begin
         desc.kind    = KIND_PAUSE;
         desc.high_us = cfg.nib_gap;
         desc.last    = last_nib && !job_ff.cmd_gap;
      end else if (q == Q_LATCH) begin
         desc.kind         = KIND_LATCH;
         desc.lead_high_us = LEAD_US;
         desc.low_us       = cfg.latch_low;
         desc.high_us      = cfg.latch_high;
      end else if (bit_val) begin
         desc.kind         = KIND_ONE;
         desc.lead_high_us = LEAD_US;
         desc.low_us       = cfg.one_low;
         desc.high_us      = cfg.one_high;
      end else begin
         desc.kind         = KIND_ZERO;
         desc.lead_high_us = LEAD_US;
         desc.low_us       = cfg.zero_low;
         desc.high_us      = cfg.zero_high;
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      nib_sel_in   = nib_sel_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      if (adv) begin
         rsp_valid_in = 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!qstat.empty) begin
                  pop        = 1'b1;
                  job_in     = job;
                  nib_sel_in = 1'b0;
                  pos_in     = '0;
                  state_in   = ST_NIB;
               end
            end
            ST_NIB: begin
               rsp_valid_in = 1'b1;
               rsp_in       = desc;
               if (pos_ff == POS_GAP) begin
                  pos_in = '0;
                  if (!last_nib) begin
                     nib_sel_in = 1'b1;
                  end else if (job_ff.cmd_gap) begin
                     state_in = ST_CMDGAP;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            ST_CMDGAP: begin
               rsp_valid_in      = 1'b1;
               rsp_in            = '0;
               rsp_in.kind       = KIND_PAUSE;
               rsp_in.high_us    = cfg.cmd_gap;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nib_sel_ff   <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nib_sel_ff   <= nib_sel_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sim/pulse_descriptor_checker.sv @@
`timescale 1ns / 1ps

module pulse_descriptor_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  lswps_pkg::req_type  req,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  lswps_pkg::rsp_type  rsp,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output int                  fail_count,
   output int                  pending
);
   import lswps_pkg::*;

   cfg_type timing;
   rsp_type expected_pulses [$];

   task automatic push_pulse(kind_type kind, logic [2:0] lead, logic [15:0] lo,
                             logic [15:0] hi);
      rsp_type d;
      d.kind         = kind;
      d.lead_high_us = lead;
      d.low_us       = lo;
      d.high_us      = hi;
      d.last         = 1'b0;
      expected_pulses.push_back(d);
   endtask

   task automatic push_bit(logic b);
      if (b) begin
         push_pulse(KIND_ONE, LEAD_US, timing.one_low, timing.one_high);
      end else begin
         push_pulse(KIND_ZERO, LEAD_US, timing.zero_low, timing.zero_high);
      end
   endtask

   // nib[4] = RS, nib[3:0] = D7..D4; two passes, enable high then low
   task automatic push_nibble(logic [4:0] nib);
      for (int pass = 0; pass < 2; pass++) begin
         push_bit(pass == 0);
         push_bit(nib[4]);
         for (int i = 3; i >= 0; i--) begin
            push_bit(nib[i]);
         end
         push_pulse(KIND_LATCH, LEAD_US, timing.latch_low, timing.latch_high);
      end
      push_pulse(KIND_PAUSE, 3'd0, 16'd0, timing.nib_gap);
   endtask

   task automatic push_command(logic [7:0] cmd);
      push_nibble({1'b0, cmd[7:4]});
      push_nibble({1'b0, cmd[3:0]});
      push_pulse(KIND_PAUSE, 3'd0, 16'd0, timing.cmd_gap);
   endtask

   task automatic predict_pulses(req_type r);
      logic [7:0] base;
      rsp_type    tail;
      case (r.op)
         OP_COMMAND: begin
            push_command(r.value);
         end
         OP_DATA: begin
            push_nibble({1'b1, r.value[7:4]});
            push_nibble({1'b1, r.value[3:0]});
         end
         OP_NIBBLE: begin
            push_nibble({1'b0, r.value[3:0]});
         end
         default: begin
            // rows other than 2..4 fall back to the row 1 base
            case (r.row)
               3'd2:    base = ROW2_BASE;
               3'd3:    base = ROW3_BASE;
               3'd4:    base = ROW4_BASE;
               default: base = ROW1_BASE;
            endcase
            push_command(base + {1'b0, r.col});
         end
      endcase
      tail      = expected_pulses.pop_back();
      tail.last = 1'b1;
      expected_pulses.push_back(tail);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         timing.zero_low   = RST_ZERO_LOW;
         timing.zero_high  = RST_ZERO_HIGH;
         timing.one_low    = RST_ONE_LOW;
         timing.one_high   = RST_ONE_HIGH;
         timing.latch_low  = RST_LATCH_LOW;
         timing.latch_high = RST_LATCH_HIGH;
         timing.nib_gap    = RST_NIB_GAP;
         timing.cmd_gap    = RST_CMD_GAP;
         expected_pulses.delete();
      end else begin
         // pop before push: a descriptor never belongs to a same-edge request
         if (rsp_valid && !rsp_stall) begin
            if (expected_pulses.size() == 0) begin
               $error("descriptor with none expected: kind %0d", rsp.kind);
               fail_count++;
            end else begin
               want = expected_pulses.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp.kind));
               check_field("lead_high_us", 16'(want.lead_high_us),
                           16'(rsp.lead_high_us));
               check_field("low_us", want.low_us, rsp.low_us);
               check_field("high_us", want.high_us, rsp.high_us);
               check_field("last", 16'(want.last), 16'(rsp.last));
            end
         end
         if (req_valid && !req_stall) begin
            predict_pulses(req);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ZERO_LOW:   timing.zero_low   = csr_wdata;
               CSR_ZERO_HIGH:  timing.zero_high  = csr_wdata;
               CSR_ONE_LOW:    timing.one_low    = csr_wdata;
               CSR_ONE_HIGH:   timing.one_high   = csr_wdata;
               CSR_LATCH_LOW:  timing.latch_low  = csr_wdata;
               CSR_LATCH_HIGH: timing.latch_high = csr_wdata;
               CSR_NIB_GAP:    timing.nib_gap    = csr_wdata;
               CSR_CMD_GAP:    timing.cmd_gap    = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_pulses.size();
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import lswps_pkg::*;

   localparam int RESET_CYCLES     = 12;
   // worst item: a command or cursor request, stretched by a 53% receiver stall
   // and sender gaps; ~460 items stay far below this
   localparam int CYCLE_LIMIT      = 400000;
   // settle time after the last expected descriptor has been checked
   localparam int DRAIN_CYCLES     = 8;
   localparam int RANDOM_PHASES    = 6;
   localparam int RANDOM_PER_PHASE = 74;

   typedef enum int {
      TIMING_DEFAULT,
      TIMING_MAX,
      TIMING_ZERO,
      TIMING_ALTERNATE,
      TIMING_RANDOM
   } timing_set_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int send_idle_pct = 0;   // chance per cycle that the sender holds off
   int recv_stall_pct = 0;  // chance per cycle that the receiver stalls

   lcd_single_wire_pulse_serializer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pulse_descriptor_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs or drops descriptors
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver backpressure, redrawn every cycle on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic req_type make_request(op_type op, logic [7:0] value,
                                            logic [2:0] row, logic [6:0] col);
      req_type r;
      r.op    = op;
      r.value = value;
      r.row   = row;
      r.col   = col;
      return r;
   endfunction

   function automatic logic [15:0] reset_value(logic [2:0] idx);
      case (idx)
         CSR_ZERO_LOW:   return RST_ZERO_LOW;
         CSR_ZERO_HIGH:  return RST_ZERO_HIGH;
         CSR_ONE_LOW:    return RST_ONE_LOW;
         CSR_ONE_HIGH:   return RST_ONE_HIGH;
         CSR_LATCH_LOW:  return RST_LATCH_LOW;
         CSR_LATCH_HIGH: return RST_LATCH_HIGH;
         CSR_NIB_GAP:    return RST_NIB_GAP;
         default:        return RST_CMD_GAP;
      endcase
   endfunction

   // Write all eight timing registers, one per cycle. Only called with the
   // block drained, so no descriptor in flight sees a half-updated set.
   task automatic load_timing(timing_set_type setting);
      logic [2:0] idx;
      idx = CSR_ZERO_LOW;
      repeat (8) begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         case (setting)
            TIMING_MAX:       csr_wdata <= 16'hFFFF;
            TIMING_ZERO:      csr_wdata <= 16'h0000;
            TIMING_ALTERNATE: csr_wdata <= idx[0] ? 16'hFFFF : 16'h0000;
            TIMING_RANDOM:    csr_wdata <= 16'($urandom_range(65535));
            default:          csr_wdata <= reset_value(idx);
         endcase
         @(negedge clock);
         idx = idx + 3'd1;
      end
      csr_we <= 1'b0;
   endtask

   // Entered and left at a falling edge. Gap cycles drop valid; once raised,
   // valid and payload hold until the request is taken.
   task automatic send_request(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random;
      req_type r;
      r.op    = op_type'($urandom_range(3));
      r.value = 8'($urandom_range(255));
      r.row   = 3'($urandom_range(7));
      r.col   = 7'($urandom_range(127));
      send_request(r);
   endtask

   // wait for every predicted descriptor, then let the pipeline settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idle_mode(int mode);
      case (mode)
         0: begin
            send_idle_pct  = 8;
            recv_stall_pct = 53;
         end
         1: begin
            send_idle_pct  = 53;
            recv_stall_pct = 8;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req       = '0;
      csr_we    = 1'b0;
      csr_index = CSR_ZERO_LOW;
      csr_wdata = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests at reset timing
      set_idle_mode(0);
      send_request(make_request(OP_COMMAND, 8'h00, 3'd0, 7'd0));
      send_request(make_request(OP_COMMAND, 8'hFF, 3'd7, 7'd127));
      send_request(make_request(OP_COMMAND, 8'h5A, 3'd2, 7'd5));
      send_request(make_request(OP_DATA, 8'h00, 3'd0, 7'd0));
      send_request(make_request(OP_DATA, 8'hFF, 3'd7, 7'd127));
      send_request(make_request(OP_DATA, 8'hA5, 3'd3, 7'd64));
      // single nibble: upper value bits must be dropped, RS stays low
      send_request(make_request(OP_NIBBLE, 8'h00, 3'd0, 7'd0));
      send_request(make_request(OP_NIBBLE, 8'h0F, 3'd0, 7'd0));
      send_request(make_request(OP_NIBBLE, 8'hF0, 3'd5, 7'd99));
      send_request(make_request(OP_NIBBLE, 8'hFF, 3'd7, 7'd127));
      // cursor: every row, including the ones that fall back to row 1
      send_request(make_request(OP_CURSOR, 8'hFF, 3'd0, 7'd1));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd1, 7'd0));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd2, 7'd1));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd3, 7'd20));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd4, 7'd20));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd5, 7'd3));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd6, 7'd127));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd7, 7'd16));
      // base + col wraps past 255
      send_request(make_request(OP_CURSOR, 8'h00, 3'd4, 7'd127));
      send_request(make_request(OP_CURSOR, 8'h00, 3'd2, 7'd127));
      drain();

      // Random requests; timing reprogrammed between phases, idle pattern
      // moves from receiver-heavy to sender-heavy to none
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idle_mode(phase / 2);
         case (phase)
            0:       load_timing(TIMING_MAX);
            1:       load_timing(TIMING_ZERO);
            3:       load_timing(TIMING_ALTERNATE);
            5:       load_timing(TIMING_DEFAULT);
            default: load_timing(TIMING_RANDOM);
         endcase
         repeat (RANDOM_PER_PHASE) send_random();
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/lswps_pkg.sv
rtl/core/lswps_front.sv
rtl/core/lswps_queue.sv
rtl/core/lswps_back.sv
rtl/core/lcd_single_wire_pulse_serializer_core.sv
sim/pulse_descriptor_checker.sv
sim/testbench.sv
